/* rtl/rmsd_pkg.sv */
// Shared types and constants for the running mean / deviation / min-max core.
// Holds the shared adder request and response, and the sequencer state codes.
// No dependencies.
package rmsd_pkg;

    localparam int ALU_W = 65;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } alu_rsp_t;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_DELTA  = 10'b0000000010,
        ST_DIV1   = 10'b0000000100,
        ST_MEAN   = 10'b0000001000,
        ST_DELTA2 = 10'b0000010000,
        ST_MUL    = 10'b0000100000,
        ST_ACC    = 10'b0001000000,
        ST_DIV2   = 10'b0010000000,
        ST_SQRT   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

endpackage

/* rtl/rmsd_alu.sv */
// Shared add/subtract unit of the running statistics core.
// Depends on rmsd_pkg for the request and response types.
module rmsd_alu (
    input  rmsd_pkg::alu_req_t req,
    output rmsd_pkg::alu_rsp_t rsp
);

    localparam int AW = rmsd_pkg::ALU_W;

    logic [AW:0] full_sum;
    logic [AW-1:0] b_in;

    assign b_in     = req.sub ? ~req.b : req.b;
    assign full_sum = {1'b0, req.a} + {1'b0, b_in} + (AW+1)'(req.sub);

    assign rsp.sum   = full_sum[AW-1:0];
    assign rsp.carry = full_sum[AW];

endmodule

/* rtl/running_mean_stddev_minmax_core.sv */
// Running statistics core: top level. Depends on rmsd_pkg and rmsd_alu.
// Sequencer and accumulators around one shared 65-bit add/subtract unit.
//
// Each beat on s_ carries one signed fixed-point sample; s_start_req clears count, mean,
// second moment, minimum and maximum before the sample is taken. One result beat on m_
// follows each sample with count, mean, sample standard deviation, minimum and maximum.
// Every listed arithmetic step uses the single shared adder: a restoring division of
// |delta| by the count (SAMPLE_BITS steps), the mean update, a shift-add multiply
// (SAMPLE_BITS steps), the moment accumulate, a restoring division of m2 by count-1
// (64 steps) and a digit-by-digit square root ((65+FRACTION_BITS)/2 steps). When the
// count is below two, the division of m2 and the square root are skipped and the
// deviation is zero. s_ready is high only between samples; a finished result waits
// in the output register while the next sample is taken.
module running_mean_stddev_minmax_core #(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_sample,
    input  logic        s_start_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sample_count,
    output logic [31:0] m_mean_value,
    output logic [31:0] m_std_deviation,
    output logic [31:0] m_min_value,
    output logic [31:0] m_max_value
);

    localparam int SB   = SAMPLE_BITS;
    localparam int FB   = FRACTION_BITS;
    localparam int AW   = rmsd_pkg::ALU_W;
    localparam int RW   = (64 + FB + 1) / 2;
    localparam int RDW  = 2 * RW;
    localparam int DVW  = 64;
    localparam int REMW = RW + 1;
    localparam int PW   = 2 * SB;
    localparam int IW   = $clog2(DVW + 1);

    localparam logic signed [SB-1:0] MIN_CLEAR = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] MAX_CLEAR = {1'b1, {(SB-1){1'b0}}};

    rmsd_pkg::state_t state_reg, state_next;

    logic [31:0]           count_reg, count_next;
    logic signed [SB-1:0]  mean_reg, mean_next;
    logic [63:0]           moment_reg, moment_next;
    logic signed [SB-1:0]  min_reg, min_next;
    logic signed [SB-1:0]  max_reg, max_next;
    logic signed [SB-1:0]  x_reg, x_next;
    logic                  neg_reg, neg_next;
    logic [SB-1:0]         mag_reg, mag_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [DVW-1:0]        dvd_reg, dvd_next;
    logic [REMW-1:0]       rem_reg, rem_next;
    logic [RW-1:0]         root_reg, root_next;
    logic [RDW-1:0]        rad_reg, rad_next;
    logic [IW-1:0]         iter_reg, iter_next;
    logic [31:0]           std_reg, std_next;

    logic                  m_valid_reg, m_valid_next;
    logic [31:0]           cnt_out_reg, mean_out_reg, std_out_reg, min_out_reg, max_out_reg;
    logic                  out_load;

    rmsd_pkg::alu_req_t    alu_req;
    rmsd_pkg::alu_rsp_t    alu_rsp;

    logic [SB+31:0]        x_wide;
    logic signed [SB-1:0]  x_in;
    logic [31:0]           count_base;
    logic signed [SB-1:0]  mean_base, min_base, max_base;
    logic [63:0]           moment_base;
    logic [31:0]           divisor;
    logic [REMW-1:0]       div_shift;
    logic [REMW+1:0]       sqrt_shift;
    logic [PW+63:0]        prod_ext;
    logic                  prod_high;
    logic [63:0]           moment_sum;
    logic [RW-1:0]         root_step;
    logic [SB+31:0]        mean_ext, min_ext, max_ext;
    logic                  last_iter;

    rmsd_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign x_wide      = {{SB{1'b0}}, s_sample};
    assign x_in        = x_wide[SB-1:0];
    assign count_base  = s_start_req ? 32'd0 : count_reg;
    assign mean_base   = s_start_req ? '0 : mean_reg;
    assign moment_base = s_start_req ? 64'd0 : moment_reg;
    assign min_base    = s_start_req ? MIN_CLEAR : min_reg;
    assign max_base    = s_start_req ? MAX_CLEAR : max_reg;

    assign divisor     = (state_reg == rmsd_pkg::ST_DIV2) ? (count_reg - 32'd1) : count_reg;
    assign div_shift   = {rem_reg[REMW-2:0], dvd_reg[DVW-1]};
    assign sqrt_shift  = {rem_reg, rad_reg[RDW-1:RDW-2]};
    assign prod_ext    = {64'd0, prod_reg} >> FB;
    assign prod_high   = |prod_ext[PW+63:64];
    assign moment_sum  = alu_rsp.sum[63:0];
    assign root_step   = {root_reg[RW-2:0], alu_rsp.carry};
    assign last_iter   = (iter_reg == IW'(1));

    always_comb begin
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        unique case (state_reg)
            rmsd_pkg::ST_DELTA, rmsd_pkg::ST_DELTA2: begin
                alu_req.a   = neg_reg ? AW'(mean_reg) : AW'(x_reg);
                alu_req.b   = neg_reg ? AW'(x_reg) : AW'(mean_reg);
                alu_req.sub = 1'b1;
            end
            rmsd_pkg::ST_DIV1, rmsd_pkg::ST_DIV2: begin
                alu_req.a   = AW'(div_shift);
                alu_req.b   = AW'(divisor);
                alu_req.sub = 1'b1;
            end
            rmsd_pkg::ST_MEAN: begin
                alu_req.a   = AW'(mean_reg);
                alu_req.b   = AW'(dvd_reg[SB-1:0]);
                alu_req.sub = neg_reg;
            end
            rmsd_pkg::ST_MUL: begin
                alu_req.a   = AW'(prod_reg[PW-1:SB]);
                alu_req.b   = prod_reg[0] ? AW'(mag_reg) : '0;
            end
            rmsd_pkg::ST_ACC: begin
                alu_req.a   = AW'(moment_reg);
                alu_req.b   = AW'(prod_ext[63:0]);
            end
            rmsd_pkg::ST_SQRT: begin
                alu_req.a   = AW'(sqrt_shift);
                alu_req.b   = AW'({root_reg, 2'b01});
                alu_req.sub = 1'b1;
            end
            default: begin
                alu_req.a   = '0;
            end
        endcase
    end

    assign out_load = (state_reg == rmsd_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        mean_next    = mean_reg;
        moment_next  = moment_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        x_next       = x_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        prod_next    = prod_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        rad_next     = rad_reg;
        iter_next    = iter_reg;
        std_next     = std_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rmsd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    count_next  = (&count_base) ? count_base : count_base + 32'd1;
                    mean_next   = mean_base;
                    moment_next = moment_base;
                    min_next    = (x_in < min_base) ? x_in : min_base;
                    max_next    = (x_in > max_base) ? x_in : max_base;
                    x_next      = x_in;
                    neg_next    = x_in < mean_base;
                    state_next  = rmsd_pkg::ST_DELTA;
                end
            end
            rmsd_pkg::ST_DELTA: begin
                mag_next   = alu_rsp.sum[SB-1:0];
                dvd_next   = DVW'(alu_rsp.sum[SB-1:0]) << (DVW - SB);
                rem_next   = '0;
                iter_next  = IW'(SB);
                state_next = rmsd_pkg::ST_DIV1;
            end
            rmsd_pkg::ST_DIV1, rmsd_pkg::ST_DIV2: begin
                rem_next  = alu_rsp.carry ? alu_rsp.sum[REMW-1:0] : div_shift;
                dvd_next  = {dvd_reg[DVW-2:0], alu_rsp.carry};
                iter_next = iter_reg - IW'(1);
                if (last_iter) begin
                    if (state_reg == rmsd_pkg::ST_DIV1) begin
                        state_next = rmsd_pkg::ST_MEAN;
                    end else begin
                        rad_next   = RDW'({dvd_reg[DVW-2:0], alu_rsp.carry}) << FB;
                        rem_next   = '0;
                        root_next  = '0;
                        iter_next  = IW'(RW);
                        state_next = rmsd_pkg::ST_SQRT;
                    end
                end
            end
            rmsd_pkg::ST_MEAN: begin
                mean_next  = alu_rsp.sum[SB-1:0];
                state_next = rmsd_pkg::ST_DELTA2;
            end
            rmsd_pkg::ST_DELTA2: begin
                prod_next  = PW'(alu_rsp.sum[SB-1:0]);
                iter_next  = IW'(SB);
                state_next = rmsd_pkg::ST_MUL;
            end
            rmsd_pkg::ST_MUL: begin
                prod_next = {alu_rsp.sum[SB:0], prod_reg[SB-1:1]};
                iter_next = iter_reg - IW'(1);
                if (last_iter) begin
                    state_next = rmsd_pkg::ST_ACC;
                end
            end
            rmsd_pkg::ST_ACC: begin
                moment_next = (prod_high || alu_rsp.sum[64]) ? '1 : moment_sum;
                if (count_reg < 32'd2) begin
                    std_next   = 32'd0;
                    state_next = rmsd_pkg::ST_DONE;
                end else begin
                    dvd_next   = (prod_high || alu_rsp.sum[64]) ? '1 : moment_sum;
                    rem_next   = '0;
                    iter_next  = IW'(DVW);
                    state_next = rmsd_pkg::ST_DIV2;
                end
            end
            rmsd_pkg::ST_SQRT: begin
                rem_next  = alu_rsp.carry ? alu_rsp.sum[REMW-1:0] : sqrt_shift[REMW-1:0];
                root_next = root_step;
                rad_next  = rad_reg << 2;
                iter_next = iter_reg - IW'(1);
                if (last_iter) begin
                    std_next   = ((root_step >> 32) != '0) ? '1 : root_step[31:0];
                    state_next = rmsd_pkg::ST_DONE;
                end
            end
            rmsd_pkg::ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = rmsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rmsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rmsd_pkg::ST_IDLE;
            count_reg   <= 32'd0;
            mean_reg    <= '0;
            moment_reg  <= 64'd0;
            min_reg     <= MIN_CLEAR;
            max_reg     <= MAX_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            mean_reg    <= mean_next;
            moment_reg  <= moment_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
        iter_reg <= iter_next;
        std_reg  <= std_next;
    end

    assign mean_ext = {{32{mean_reg[SB-1]}}, mean_reg};
    assign min_ext  = {{32{min_reg[SB-1]}}, min_reg};
    assign max_ext  = {{32{max_reg[SB-1]}}, max_reg};

    always_ff @(posedge aclk) begin
        if (out_load) begin
            cnt_out_reg  <= count_reg;
            mean_out_reg <= mean_ext[31:0];
            std_out_reg  <= std_reg;
            min_out_reg  <= min_ext[31:0];
            max_out_reg  <= max_ext[31:0];
        end
    end

    assign s_ready         = (state_reg == rmsd_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_sample_count  = cnt_out_reg;
    assign m_mean_value    = mean_out_reg;
    assign m_std_deviation = std_out_reg;
    assign m_min_value     = min_out_reg;
    assign m_max_value     = max_out_reg;

endmodule

/* rtl/rmsd_checker.sv */
// Port-level checks for the running statistics core, and their bind.
// Depends on running_mean_stddev_minmax_core; sees its ports only.
module rmsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_sample_count,
    input logic [31:0] m_mean_value,
    input logic [31:0] m_std_deviation,
    input logic [31:0] m_min_value,
    input logic [31:0] m_max_value
);

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid straight after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_count) && $stable(m_mean_value)
            && $stable(m_std_deviation))
        else $error("stalled result beat dropped or changed");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sample beat taken while previous sample still in work");

    a_low_count_dev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sample_count != 32'd0
            && (m_sample_count != 32'd1 || m_std_deviation == 32'd0))
        else $error("deviation nonzero with fewer than two samples");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $signed(m_min_value) <= $signed(m_mean_value)
            && $signed(m_mean_value) <= $signed(m_max_value))
        else $error("mean outside minimum and maximum");

endmodule

bind running_mean_stddev_minmax_core rmsd_checker u_rmsd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_sample_count  (m_sample_count),
    .m_mean_value    (m_mean_value),
    .m_std_deviation (m_std_deviation),
    .m_min_value     (m_min_value),
    .m_max_value     (m_max_value)
);

/* verif/rmsd_stats_monitor.sv */
// Beat monitor and predictor for running_mean_stddev_minmax_core.
// Follows both channels, predicts count, mean, deviation, min and max per sample
// and compares them with the result beats. Standalone: needs no package or RTL source.
module rmsd_stats_monitor #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_sample,
    input  logic        s_start_req,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_sample_count,
    input  logic [31:0] m_mean_value,
    input  logic [31:0] m_std_deviation,
    input  logic [31:0] m_min_value,
    input  logic [31:0] m_max_value,
    output int          mismatch_count,
    output int          pending
);

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] mean;
        logic [31:0] stddev;
        logic [31:0] minimum;
        logic [31:0] maximum;
    } stats_t;

    stats_t expected_stats[$];

    logic [31:0]        acc_count;
    logic signed [63:0] acc_mean;
    logic [63:0]        acc_m2;
    logic signed [63:0] acc_min;
    logic signed [63:0] acc_max;

    initial begin
        mismatch_count = 0;
        pending        = 0;
    end

    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [127:0] square;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial  = root | (64'd1 << b);
            square = {64'd0, trial} * {64'd0, trial};
            if (square <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    task automatic clear_stats();
        acc_count = '0;
        acc_mean  = '0;
        acc_m2    = '0;
        acc_min   = 64'sd2147483647;
        acc_max   = -64'sd2147483648;
    endtask

    task automatic welford_update(input logic [31:0] smp, input logic clr, output stats_t res);
        logic signed [63:0] x;
        logic signed [63:0] delta;
        logic signed [63:0] delta2;
        logic signed [63:0] step;
        logic [63:0]        mag_d;
        logic [63:0]        mag_d2;
        logic [63:0]        quot;
        logic [63:0]        root;
        logic [127:0]       prod;
        logic [127:0]       scaled;
        x = {{32{smp[31]}}, smp};
        if (clr) begin
            clear_stats();
        end
        if (acc_count != 32'hFFFF_FFFF) begin
            acc_count = acc_count + 32'd1;
        end
        delta = x - acc_mean;
        mag_d = (delta < 0) ? -delta : delta;
        step  = mag_d / {32'd0, acc_count};
        if (delta < 0) begin
            step = -step;
        end
        acc_mean = acc_mean + step;
        delta2   = x - acc_mean;
        mag_d2   = (delta2 < 0) ? -delta2 : delta2;
        prod     = {64'd0, mag_d} * {64'd0, mag_d2};
        scaled   = prod >> FRACTION_BITS;
        if (scaled[127:64] != '0 || scaled[63:0] > ~acc_m2) begin
            acc_m2 = '1;
        end else begin
            acc_m2 = acc_m2 + scaled[63:0];
        end
        if (x < acc_min) begin
            acc_min = x;
        end
        if (x > acc_max) begin
            acc_max = x;
        end
        if (acc_count < 32'd2) begin
            root = '0;
        end else begin
            quot = acc_m2 / {32'd0, acc_count - 32'd1};
            root = floor_sqrt({64'd0, quot} << FRACTION_BITS);
            if (root > 64'hFFFF_FFFF) begin
                root = 64'hFFFF_FFFF;
            end
        end
        res.count   = acc_count;
        res.mean    = acc_mean[31:0];
        res.stddev  = root[31:0];
        res.minimum = acc_min[31:0];
        res.maximum = acc_max[31:0];
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            $error("%s: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        stats_t want;
        stats_t got;
        if (!aresetn) begin
            clear_stats();
            expected_stats.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_stats.size() == 0) begin
                    mismatch_count++;
                    $error("result beat with no sample outstanding");
                end else begin
                    want = expected_stats.pop_front();
                    compare_field("sample_count",  want.count,   m_sample_count);
                    compare_field("mean_value",    want.mean,    m_mean_value);
                    compare_field("std_deviation", want.stddev,  m_std_deviation);
                    compare_field("min_value",     want.minimum, m_min_value);
                    compare_field("max_value",     want.maximum, m_max_value);
                end
            end
            if (s_valid && s_ready) begin
                welford_update(s_sample, s_start_req, got);
                expected_stats.insert(expected_stats.size(), got);
            end
            pending <= expected_stats.size();
        end
    end

endmodule

/* verif/tb.sv */
// Top-level testbench for running_mean_stddev_minmax_core.
// Drives directed then random sample sequences in bursts with a stalling receiver;
// checking is done by rmsd_stats_monitor.
module tb;

    localparam int N_ITEMS      = 1600;
    localparam int LIMIT        = 3_000_000;
    localparam int DRAIN_CYCLES = 400;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [31:0] s_sample    = '0;
    logic        s_start_req = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [31:0] m_sample_count;
    logic [31:0] m_mean_value;
    logic [31:0] m_std_deviation;
    logic [31:0] m_min_value;
    logic [31:0] m_max_value;

    int          fail_count;
    int          pending;
    int          samples_sent = 0;
    int          burst_left   = 0;
    int unsigned stall_left   = 0;
    int          stall_mode   = 0;

    running_mean_stddev_minmax_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_start_req     (s_start_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_count  (m_sample_count),
        .m_mean_value    (m_mean_value),
        .m_std_deviation (m_std_deviation),
        .m_min_value     (m_min_value),
        .m_max_value     (m_max_value)
    );

    rmsd_stats_monitor u_stats_mon (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_start_req     (s_start_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_count  (m_sample_count),
        .m_mean_value    (m_mean_value),
        .m_std_deviation (m_std_deviation),
        .m_min_value     (m_min_value),
        .m_max_value     (m_max_value),
        .mismatch_count  (fail_count),
        .pending         (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("tb NOT OK");
        $finish;
    end

    // receiver: hold each stall mode for a random stretch
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= stall_left[3];
        endcase
    end

    task automatic push_sample(input logic [31:0] smp, input logic clr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_sample    <= smp;
        s_start_req <= clr;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    function automatic logic [31:0] pick_sample(input logic [31:0] centre);
        logic [31:0] spread;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return $urandom();
            3, 4: return 32'($urandom_range(0, 131072)) - 32'd65536;
            default: begin
                spread = 32'd1 << $urandom_range(0, 30);
                return centre + ($urandom() & ((spread << 1) - 32'd1)) - spread;
            end
        endcase
    endfunction

    initial begin
        int          seq_len;
        logic [31:0] centre;
        logic        broken;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // accumulate straight from reset, no clear
        push_sample(32'h0001_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        // clear together with a sample, then a zero delta
        push_sample(32'h8000_0000, 1'b1);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        // widest spread at a count of two
        push_sample(32'h7FFF_FFFF, 1'b1);
        push_sample(32'h8000_0000, 1'b0);
        // negative mean step truncating toward zero
        push_sample(32'h0000_0000, 1'b1);
        push_sample(32'hFFFF_FFFD, 1'b0);
        push_sample(32'h0000_0001, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h5555_5555, 1'b1);
        push_sample(32'hAAAA_AAAA, 1'b0);
        // constant input: zero deviation
        push_sample(32'h0000_0000, 1'b1);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        // clear on consecutive beats
        push_sample(32'hFFFF_0000, 1'b1);
        push_sample(32'h0001_0000, 1'b1);

        while (samples_sent < N_ITEMS) begin
            broken  = ($urandom_range(0, 9) == 0);
            seq_len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 30);
            centre  = $urandom();
            for (int i = 0; i < seq_len; i++) begin
                push_sample(pick_sample(centre),
                            broken ? ($urandom_range(0, 3) == 0) : (i == 0));
            end
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
